FILE: rtl/hbcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbcl_pkg
// shared types, codes and widths of the hashed block cache directory
// ----------------------------------------------------------------------------
package hbcl_pkg;

  localparam int DEF_BUFFERS     = 32;
  localparam int DEF_NUM_BUCKETS = 13;

  localparam int IDX_W   = 8;   // covers the largest entry count
  localparam int DEV_W   = 8;
  localparam int BLK_W   = 32;
  localparam int CNT_W   = 8;
  localparam int STAMP_W = 32;
  localparam int BKT_W   = 6;   // covers the largest bucket count

  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  localparam logic [1:0] CMD_GET     = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_PIN     = 2'd2;
  localparam logic [1:0] CMD_UNPIN   = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_UNDER  = 2'd2;
  localparam logic [1:0] ST_SAT    = 2'd3;

  // request seen by every cell
  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    logic [BKT_W-1:0] home;
    logic [IDX_W-1:0] tgt;
  } req_t;

  // running search record handed along the chain
  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [CNT_W-1:0]   hit_cnt;
    logic               hit_valid;
    logic               hb_ok;
    logic [IDX_W-1:0]   hb_idx;
    logic [STAMP_W-1:0] hb_stamp;
    logic               ob_ok;
    logic [IDX_W-1:0]   ob_idx;
    logic [STAMP_W-1:0] ob_stamp;
    logic [CNT_W-1:0]   tgt_cnt;
  } scan_rec_t;

  // write-back broadcast to the cells
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [CNT_W-1:0]   cnt;
    logic               stamp_en;
    logic [STAMP_W-1:0] stamp;
    logic               key_en;
    logic [DEV_W-1:0]   dev;
    logic [BLK_W-1:0]   blk;
    logic [BKT_W-1:0]   bucket;
    logic               valid_en;
  } wb_t;

endpackage

FILE: rtl/hbcl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbcl_cell
// one directory entry plus one stage of the search chain
// ----------------------------------------------------------------------------
module hbcl_cell import hbcl_pkg::*; #(
  parameter int MY_IDX      = 0,
  parameter int NUM_BUCKETS = DEF_NUM_BUCKETS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  req_t      req,
  input  wb_t       wb,
  input  scan_rec_t rec_in,
  output scan_rec_t rec_out
);

  localparam logic [IDX_W-1:0] ME        = IDX_W'(MY_IDX);
  localparam logic [BKT_W-1:0] RST_BKT   = BKT_W'(MY_IDX % NUM_BUCKETS);

  logic [DEV_W-1:0]   dev_r;
  logic [BLK_W-1:0]   blk_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [STAMP_W-1:0] stamp_r;
  logic               valid_r;
  logic [BKT_W-1:0]   bkt_r;
  scan_rec_t          rec_r;
  scan_rec_t          rec_nxt;

  logic in_home, is_free, mine;

  always_comb begin
    in_home = (bkt_r == req.home);
    is_free = (cnt_r == '0);
    rec_nxt = rec_in;
    if (!rec_in.hit && in_home && dev_r == req.dev && blk_r == req.blk) begin
      rec_nxt.hit       = 1'b1;
      rec_nxt.hit_idx   = ME;
      rec_nxt.hit_cnt   = cnt_r;
      rec_nxt.hit_valid = valid_r;
    end
    // strict compare keeps the lowest index on equal stamps
    if (is_free && in_home && (!rec_in.hb_ok || stamp_r < rec_in.hb_stamp)) begin
      rec_nxt.hb_ok    = 1'b1;
      rec_nxt.hb_idx   = ME;
      rec_nxt.hb_stamp = stamp_r;
    end
    if (is_free && !in_home && (!rec_in.ob_ok || stamp_r < rec_in.ob_stamp)) begin
      rec_nxt.ob_ok    = 1'b1;
      rec_nxt.ob_idx   = ME;
      rec_nxt.ob_stamp = stamp_r;
    end
    if (req.tgt == ME) begin
      rec_nxt.tgt_cnt = cnt_r;
    end
  end

  assign mine    = wb.en && (wb.idx == ME);
  assign rec_out = rec_r;

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    if (!rst_n) begin
      dev_r   <= '0;
      blk_r   <= '0;
      cnt_r   <= '0;
      stamp_r <= '0;
      valid_r <= 1'b0;
      bkt_r   <= RST_BKT;
    end else if (mine) begin
      cnt_r <= wb.cnt;
      if (wb.stamp_en) stamp_r <= wb.stamp;
      if (wb.valid_en) valid_r <= 1'b1;
      if (wb.key_en) begin
        dev_r <= wb.dev;
        blk_r <= wb.blk;
        bkt_r <= wb.bucket;
      end
    end
  end

endmodule

FILE: rtl/hashed_block_cache_lru.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_block_cache_lru
// hashed buffer cache directory with timestamp lru recycling
// ----------------------------------------------------------------------------
// a word is handled in order: bucket hashing, one block byte at a time,
//   then the search record walks the cell chain, registered in each cell,
//   then the write-back, with the result registered onto out_valid
// busy is high from accept until the result strobe; no new word is taken meanwhile
// results are shown for one cycle on out_valid; the receiver cannot stall
// reset (rst_n low, synchronous) empties every entry and puts entry i in
//   bucket i modulo NUM_BUCKETS
// ----------------------------------------------------------------------------
module hashed_block_cache_lru import hbcl_pkg::*; #(
  parameter int BUFFERS     = DEF_BUFFERS,
  parameter int NUM_BUCKETS = DEF_NUM_BUCKETS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  logic [1:0]   in_cmd,
  input  logic [7:0]   in_device,
  input  logic [31:0]  in_block_number,
  input  logic [4:0]   in_buffer_index,
  input  logic [31:0]  in_now,
  output logic         out_valid,
  output logic [4:0]   out_buffer_out,
  output logic         out_needs_read,
  output logic [1:0]   out_status
);

  localparam int CW = $clog2(BUFFERS + 1) < 2 ? 2 : $clog2(BUFFERS + 1);
  localparam logic [CW-1:0] SCAN_LEN = CW'(BUFFERS);
  localparam logic [CW-1:0] HASH_LAST = CW'(3);
  localparam logic [BKT_W:0] NB_VAL = (BKT_W+1)'(NUM_BUCKETS);

  // controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HASH = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  req_t          req_r;
  logic [1:0]    cmd_r;
  logic [31:0]   now_r;

  logic          out_valid_r;
  logic [4:0]    out_buf_r;
  logic          out_rd_r;
  logic [1:0]    out_st_r;

  // one bit step of block modulo bucket count: shift in, subtract once
  function automatic logic [BKT_W-1:0] mod_bit(input logic [BKT_W-1:0] r,
                                               input logic b);
    logic [BKT_W:0] t;
    t = {r, b};
    if (t >= NB_VAL) t = t - NB_VAL;
    return t[BKT_W-1:0];
  endfunction

  logic [7:0]       hash_byte;
  logic [BKT_W-1:0] home_nxt;

  // msb byte first
  assign hash_byte = 8'(req_r.blk >> (5'd24 - {cnt_r[1:0], 3'b000}));

  // msb bit first within the byte
  always_comb begin
    home_nxt = req_r.home;
    for (int i = 7; i >= 0; i--) home_nxt = mod_bit(home_nxt, hash_byte[i]);
  end

  // cell chain
  scan_rec_t rec [BUFFERS+1];
  wb_t       wb;

  assign rec[0] = '0;

  for (genvar g = 0; g < BUFFERS; g++) begin : g_cell
    hbcl_cell #(
      .MY_IDX      (g),
      .NUM_BUCKETS (NUM_BUCKETS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .req     (req_r),
      .wb      (wb),
      .rec_in  (rec[g]),
      .rec_out (rec[g+1])
    );
  end

  scan_rec_t fin;
  logic      finish;
  logic [4:0] res_buf;
  logic       res_rd;
  logic [1:0] res_st;

  assign fin    = rec[BUFFERS];
  assign finish = (state_r == S_SCAN) && (cnt_r == SCAN_LEN);

  // decide result and write-back from the finished search record
  always_comb begin
    wb       = '0;
    wb.stamp = now_r;
    wb.dev   = req_r.dev;
    wb.blk   = req_r.blk;
    wb.bucket = req_r.home;
    res_buf  = req_r.tgt[4:0];
    res_rd   = 1'b0;
    res_st   = ST_OK;
    if (cmd_r == CMD_GET) begin
      if (fin.hit) begin
        res_buf = fin.hit_idx[4:0];
        if (fin.hit_cnt == CNT_MAX) begin
          res_st = ST_SAT;
        end else begin
          res_rd      = !fin.hit_valid;
          wb.en       = 1'b1;
          wb.idx      = fin.hit_idx;
          wb.cnt      = fin.hit_cnt + 8'd1;
          wb.stamp_en = 1'b1;
          wb.valid_en = 1'b1;
        end
      end else if (fin.hb_ok || fin.ob_ok) begin
        // home bucket first, else steal from another bucket
        wb.idx      = fin.hb_ok ? fin.hb_idx : fin.ob_idx;
        res_buf     = wb.idx[4:0];
        res_rd      = 1'b1;
        wb.en       = 1'b1;
        wb.cnt      = 8'd1;
        wb.stamp_en = 1'b1;
        wb.key_en   = 1'b1;
        wb.valid_en = 1'b1;
      end else begin
        res_buf = '0;
        res_st  = ST_NOFREE;
      end
    end else if (int'(req_r.tgt) >= BUFFERS) begin
      res_st = ST_NOFREE;
    end else if (cmd_r == CMD_PIN) begin
      if (fin.tgt_cnt == CNT_MAX) begin
        res_st = ST_SAT;
      end else begin
        wb.en  = 1'b1;
        wb.idx = req_r.tgt;
        wb.cnt = fin.tgt_cnt + 8'd1;
      end
    end else begin
      if (fin.tgt_cnt == '0) begin
        res_st = ST_UNDER;
      end else begin
        wb.en       = 1'b1;
        wb.idx      = req_r.tgt;
        wb.cnt      = fin.tgt_cnt - 8'd1;
        // last release refreshes the stamp, unpin never does
        wb.stamp_en = (cmd_r == CMD_RELEASE) && (fin.tgt_cnt == 8'd1);
      end
    end
    wb.en = wb.en && finish;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 1'b1;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (start) state_nxt = S_HASH;
      end
      S_HASH: begin
        if (cnt_r == HASH_LAST) begin
          state_nxt = S_SCAN;
          cnt_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (finish) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= finish;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      cmd_r      <= in_cmd;
      now_r      <= in_now;
      req_r.dev  <= in_device;
      req_r.blk  <= in_block_number;
      req_r.tgt  <= IDX_W'(in_buffer_index);
      req_r.home <= '0;
    end else if (state_r == S_HASH) begin
      req_r.home <= home_nxt;
    end
    if (finish) begin
      out_buf_r <= res_buf;
      out_rd_r  <= res_rd;
      out_st_r  <= res_st;
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_buffer_out = out_buf_r;
  assign out_needs_read = out_rd_r;
  assign out_status     = out_st_r;

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_strobe_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == S_SCAN)
    else $error("result without a finished scan");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> cnt_r <= SCAN_LEN)
    else $error("scan counter overran the chain");

  a_wb_once: assert property (@(posedge clk) disable iff (!rst_n)
    wb.en |-> finish)
    else $error("write-back outside the finish cycle");

endmodule

FILE: tb/hashed_block_cache_lru_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_block_cache_lru_checker
// predicts every result word of the cache directory and compares it with
// the block's output, counting mismatches for the test top
// ----------------------------------------------------------------------------
module hashed_block_cache_lru_checker import hbcl_pkg::*; #(
  parameter int BUFFERS     = DEF_BUFFERS,
  parameter int NUM_BUCKETS = DEF_NUM_BUCKETS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_device,
  input  logic [31:0] in_block_number,
  input  logic [4:0]  in_buffer_index,
  input  logic [31:0] in_now,
  input  logic        out_valid,
  input  logic [4:0]  out_buffer_out,
  input  logic        out_needs_read,
  input  logic [1:0]  out_status,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [4:0] buf_idx;
    logic       rd;
    logic [1:0] st;
  } dir_reply_t;

  logic [DEV_W-1:0]   m_dev   [BUFFERS];
  logic [BLK_W-1:0]   m_blk   [BUFFERS];
  logic [CNT_W-1:0]   m_cnt   [BUFFERS];
  logic [STAMP_W-1:0] m_stamp [BUFFERS];
  logic               m_vld   [BUFFERS];
  int                 m_bkt   [BUFFERS];

  dir_reply_t replies_due[$];

  function automatic int oldest_free(int home, bit same);
    int pick;
    pick = -1;
    for (int i = 0; i < BUFFERS; i++) begin
      if (((m_bkt[i] == home) == same) && m_cnt[i] == 0)
        if (pick < 0 || m_stamp[i] < m_stamp[pick]) pick = i;
    end
    return pick;
  endfunction

  function automatic dir_reply_t apply_word(logic [1:0] cmd, logic [7:0] dev,
                                            logic [31:0] blk, logic [4:0] idx,
                                            logic [31:0] now);
    dir_reply_t r;
    int home;
    int pick;
    r = '0;
    if (cmd == CMD_GET) begin
      home = int'(blk % NUM_BUCKETS);
      for (int i = 0; i < BUFFERS; i++) begin
        if (m_bkt[i] == home && m_dev[i] == dev && m_blk[i] == blk) begin
          r.buf_idx = i[4:0];
          if (m_cnt[i] == CNT_MAX) begin
            r.st = ST_SAT;
          end else begin
            m_cnt[i]++;
            m_stamp[i] = now;
            r.rd = !m_vld[i];
            m_vld[i] = 1'b1;
            r.st = ST_OK;
          end
          return r;
        end
      end
      pick = oldest_free(home, 1'b1);
      if (pick < 0) pick = oldest_free(home, 1'b0);
      if (pick < 0) begin
        r.st = ST_NOFREE;
        return r;
      end
      m_dev[pick] = dev;
      m_blk[pick] = blk;
      m_cnt[pick] = 1;
      m_stamp[pick] = now;
      m_bkt[pick] = home;
      m_vld[pick] = 1'b1;
      r.buf_idx = pick[4:0];
      r.rd = 1'b1;
      return r;
    end
    r.buf_idx = idx;
    if (int'(idx) >= BUFFERS) begin
      r.st = ST_NOFREE;
    end else if (cmd == CMD_PIN) begin
      if (m_cnt[idx] == CNT_MAX) r.st = ST_SAT;
      else m_cnt[idx]++;
    end else if (m_cnt[idx] == 0) begin
      r.st = ST_UNDER;
    end else begin
      m_cnt[idx]--;
      if (cmd == CMD_RELEASE && m_cnt[idx] == 0) m_stamp[idx] = now;
    end
    return r;
  endfunction

  assign pending = replies_due.size();

  always @(posedge clk) begin
    dir_reply_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < BUFFERS; i++) begin
        m_dev[i] = '0; m_blk[i] = '0; m_cnt[i] = '0;
        m_stamp[i] = '0; m_vld[i] = 1'b0; m_bkt[i] = i % NUM_BUCKETS;
      end
      replies_due.delete();
      fail_count <= 0;
    end else begin
      // result first: it belongs to a word accepted earlier
      if (out_valid) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected word buf=%0d rd=%0d st=%0d", $time,
                   out_buffer_out, out_needs_read, out_status);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = replies_due.pop_front();
          if (exp_r.buf_idx !== out_buffer_out || exp_r.rd !== out_needs_read ||
              exp_r.st !== out_status) begin
            $display("%0t: mismatch expected buf=%0d rd=%0d st=%0d actual buf=%0d rd=%0d st=%0d",
                     $time, exp_r.buf_idx, exp_r.rd, exp_r.st,
                     out_buffer_out, out_needs_read, out_status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        replies_due.push_back(apply_word(in_cmd, in_device, in_block_number,
                                         in_buffer_index, in_now));
    end
  end

endmodule

FILE: tb/hashed_block_cache_lru_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_block_cache_lru_test
// drives directed and random get, release, pin and unpin words into the
// cache directory; the checker predicts and compares every result word
// ----------------------------------------------------------------------------
module hashed_block_cache_lru_test;
  import hbcl_pkg::*;

  localparam int N_RANDOM = 832;
  localparam int STALL_LIMIT = 5000;   // idle cycles with neither an accept nor a result

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd = CMD_GET;
  logic [7:0]  in_device = '0;
  logic [31:0] in_block_number = '0;
  logic [4:0]  in_buffer_index = '0;
  logic [31:0] in_now = '0;
  logic        out_valid;
  logic [4:0]  out_buffer_out;
  logic        out_needs_read;
  logic [1:0]  out_status;
  int          fail_count;
  int          pending;
  int          quiet_cycles = 0;
  logic [31:0] tick = 32'd100;

  // small working set of blocks so hits, recycling and bucket moves all happen
  logic [31:0] hot_blk [8];
  logic [7:0]  hot_dev [8];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hashed_block_cache_lru dut (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_device, .in_block_number,
    .in_buffer_index, .in_now, .out_valid, .out_buffer_out, .out_needs_read,
    .out_status
  );

  hashed_block_cache_lru_checker chk (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_device, .in_block_number,
    .in_buffer_index, .in_now, .out_valid, .out_buffer_out, .out_needs_read,
    .out_status, .fail_count, .pending
  );

  // watchdog: counts cycles with neither an accepted input nor a result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // present one word and hold it until the block takes it
  task automatic send_word(logic [1:0] cmd, logic [7:0] dev, logic [31:0] blk,
                           logic [4:0] idx, logic [31:0] now);
    start <= 1'b1;
    in_cmd <= cmd;
    in_device <= dev;
    in_block_number <= blk;
    in_buffer_index <= idx;
    in_now <= now;
    // busy is stable at the falling edge; the next rising edge accepts
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // random gap: mostly none or short, now and then long
  task automatic idle_gap();
    int n;
    n = 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: n = 0;
      5, 6, 7, 8:    n = $urandom_range(1, 4);
      default:       n = $urandom_range(20, 120);
    endcase
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic next_tick();
    // mostly rising time, sometimes a jump to a random time to mix up ages
    if ($urandom_range(0, 15) == 0) tick = $urandom();
    else tick = tick + $urandom_range(0, 3);
  endtask

  initial begin
    logic [1:0] cmd;
    int k;
    for (int i = 0; i < 8; i++) begin
      hot_blk[i] = $urandom_range(0, 40);
      hot_dev[i] = 8'($urandom_range(0, 3));
    end
    hot_blk[7] = 32'hFFFF_FFFF;
    hot_dev[7] = 8'hFF;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: hit on a never-used entry, extremes, every command
    send_word(CMD_GET, 8'd0, 32'd0, 5'd0, 32'd0);
    send_word(CMD_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
    send_word(CMD_RELEASE, 8'd0, 32'd0, 5'd0, 32'd7);
    send_word(CMD_RELEASE, 8'd0, 32'd0, 5'd0, 32'd8);     // underflow
    send_word(CMD_UNPIN, 8'd0, 32'd0, 5'd5, 32'd9);       // underflow
    send_word(CMD_PIN, 8'd0, 32'd0, 5'd31, 32'd1);
    send_word(CMD_UNPIN, 8'd0, 32'd0, 5'd31, 32'd2);      // leaves stamp alone
    send_word(CMD_GET, 8'd3, 32'd13, 5'd0, 32'd10);
    send_word(CMD_GET, 8'd3, 32'd13, 5'd0, 32'd11);       // real hit
    // saturate entry 1 by pins, then a pin on it and a get that misses in its bucket
    for (int i = 0; i < 256; i++) send_word(CMD_PIN, 8'd0, 32'd0, 5'd1, 32'd0);
    send_word(CMD_GET, 8'd0, 32'd1, 5'd0, 32'd12);
    // fill every entry so a get finds nothing free
    for (int i = 0; i < 34; i++)
      send_word(CMD_GET, 8'd9, 32'd1000 + i, 5'd0, 32'd20 + i);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    // release everything except entry 1 so recycling has free entries again
    for (int i = 0; i < 32; i++)
      if (i != 1) send_word(CMD_RELEASE, 8'd0, 32'd0, i[4:0], $urandom());
    for (int i = 0; i < 32; i++)
      send_word(CMD_UNPIN, 8'd0, 32'd0, i[4:0], 32'd0);
    for (int i = 0; i < 255; i++) send_word(CMD_UNPIN, 8'd0, 32'd0, 5'd1, 32'd0);

    // random part: gets, mostly on a hot set, balanced by releases
    for (int n = 0; n < N_RANDOM; n++) begin
      next_tick();
      k = $urandom_range(0, 7);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: cmd = CMD_GET;
        4, 5, 6:    cmd = CMD_RELEASE;
        7:          cmd = CMD_PIN;
        default:    cmd = CMD_UNPIN;
      endcase
      if (cmd == CMD_GET && $urandom_range(0, 4) == 0)
        send_word(cmd, 8'($urandom()), $urandom(), 5'($urandom()), tick);
      else if (cmd == CMD_GET)
        send_word(cmd, hot_dev[k], hot_blk[k], 5'($urandom()), tick);
      else
        send_word(cmd, 8'($urandom()), $urandom(), 5'($urandom()), tick);
      idle_gap();
      if (n == N_RANDOM / 2) begin
        // hold off until the block has answered everything
        start <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/hbcl_pkg.sv
rtl/hbcl_cell.sv
rtl/hashed_block_cache_lru.sv
tb/hashed_block_cache_lru_checker.sv
tb/hashed_block_cache_lru_test.sv
